>>> rtl/fa_pkg.sv
// Package for the fixed-point arcsine block: constants, coefficient table and
// the elaboration-time coefficient rounding. No dependencies.
package fa_pkg;

  // Default number of fraction bits of every fixed-point value.
  localparam int unsigned FRAC_BITS_DEF = 14;

  // Width of the argument and of the angle.
  localparam int unsigned DATA_W = 16;

  // Degree of the polynomial, i.e. the number of multiply-add steps.
  localparam int unsigned HORNER_STEPS = 7;

  // Polynomial coefficients in Q30, highest power first, signs included.
  // The last entry is pi/2, which also restores the sign at the output.
  localparam longint HORNER_Q30 [0:HORNER_STEPS] = '{
    -64'sd1355589,
     64'sd7161955,
    -64'sd18348235,
     64'sd33169905,
    -64'sd53874249,
     64'sd95540460,
    -64'sd230423709,
     64'sd1686629690
  };

  localparam longint HALF_PI_Q30 = 64'sd1686629690;

  // Rounds a Q30 constant to the given number of fraction bits, half away
  // from zero. Only called on constants at elaboration.
  function automatic longint coef_round(input longint q30, input int unsigned frac);
    longint      mag;
    int unsigned sh;
    sh = 30 - frac;
    if (sh == 0) begin
      return q30;
    end
    mag = (q30 < 0) ? -q30 : q30;
    mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
    return (q30 < 0) ? -mag : mag;
  endfunction

endpackage

>>> rtl/fa_isqrt.sv
// Pipelined integer square root, rounded to nearest, one result bit per stage.
// Depends on fa_pkg.
module fa_isqrt #(
  parameter int unsigned FRAC_BITS = fa_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [FRAC_BITS:0]   omx_i,
  output logic                 valid_o,
  output logic [FRAC_BITS:0]   root_o
);
  import fa_pkg::*;

  // The radicand is omx_i with FRAC_BITS zero bits appended.
  localparam int unsigned NW    = 2 * FRAC_BITS + 1;
  localparam int unsigned ITERS = FRAC_BITS + 1;
  localparam int unsigned LAT   = ITERS + 1;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic [NW-1:0] rem_q [1:ITERS];
  logic [NW-1:0] res_q [1:ITERS];
  logic          vld_q [1:ITERS];

  logic [NW-1:0] rem_src [0:ITERS-1];
  logic [NW-1:0] res_src [0:ITERS-1];
  logic          vld_src [0:ITERS-1];
  logic [NW-1:0] rem_d   [0:ITERS-1];
  logic [NW-1:0] res_d   [0:ITERS-1];

  logic [FRAC_BITS:0] root_q;
  logic               vout_q;

  always_comb begin
    logic [NW:0] bit_c;
    logic [NW:0] sum_c;
    for (int i = 0; i < ITERS; i++) begin
      if (i == 0) begin
        rem_src[i] = {omx_i, {FRAC_BITS{1'b0}}};
        res_src[i] = '0;
        vld_src[i] = valid_i;
      end else begin
        rem_src[i] = rem_q[i];
        res_src[i] = res_q[i];
        vld_src[i] = vld_q[i];
      end
      bit_c = (NW + 1)'(1) << (2 * (FRAC_BITS - i));
      sum_c = {1'b0, res_src[i]} + bit_c;
      if ({1'b0, rem_src[i]} >= sum_c) begin
        rem_d[i] = rem_src[i] - sum_c[NW-1:0];
        res_d[i] = (res_src[i] >> 1) + bit_c[NW-1:0];
      end else begin
        rem_d[i] = rem_src[i];
        res_d[i] = res_src[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ITERS; i++) begin
      rem_q[i+1] <= rem_d[i];
      res_q[i+1] <= res_d[i];
    end
    root_q <= res_q[ITERS][FRAC_BITS:0]
              + (FRAC_BITS + 1)'(rem_q[ITERS] > res_q[ITERS]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= ITERS; i++) begin
        vld_q[i] <= 1'b0;
      end
      vout_q <= 1'b0;
    end else begin
      for (int i = 0; i < ITERS; i++) begin
        vld_q[i+1] <= vld_src[i];
      end
      vout_q <= vld_q[ITERS];
    end
  end

  assign valid_o = vout_q;
  assign root_o  = root_q;

  a_lat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##LAT valid_o)
    else $error("square root valid out of step with its input");

  a_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> root_o <= ONE)
    else $error("square root above one");

  a_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(omx_i, LAT) == '0) |-> root_o == '0)
    else $error("clamped argument gave a nonzero root");

endmodule

>>> rtl/fa_horner.sv
// Pipelined Horner evaluation of the arccosine polynomial, two stages per step
// (product, then round and add). Depends on fa_pkg.
module fa_horner #(
  parameter int unsigned FRAC_BITS = fa_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [((FRAC_BITS < 16) ? FRAC_BITS : 16)-1:0] m_i,
  output logic                                valid_o,
  output logic signed [FRAC_BITS+2:0]         p_o
);
  import fa_pkg::*;

  localparam int unsigned MW  = (FRAC_BITS < 16) ? FRAC_BITS : 16;
  localparam int unsigned PW  = FRAC_BITS + 3;
  localparam int unsigned PRW = PW + MW + 1;
  localparam int unsigned NS  = HORNER_STEPS;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) << (FRAC_BITS - 1);

  function automatic logic signed [PW-1:0] coef_at(input int unsigned idx);
    return PW'(coef_round(HORNER_Q30[idx], FRAC_BITS));
  endfunction

  logic signed [PRW-1:0] prod_q   [0:NS-1];
  logic [MW-1:0]         m_prod_q [0:NS-2];
  logic                  v_prod_q [0:NS-1];
  logic signed [PW-1:0]  p_q      [1:NS];
  logic [MW-1:0]         m_p_q    [1:NS-1];
  logic                  v_p_q    [1:NS];

  logic signed [PW-1:0]  p_src    [0:NS-1];
  logic [MW-1:0]         m_src    [0:NS-1];
  logic                  v_src    [0:NS-1];
  logic signed [PW-1:0]  p_d      [0:NS-1];

  always_comb begin
    logic signed [PRW-1:0] rnd_c;
    logic signed [PRW-1:0] sh_c;
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        p_src[j] = coef_at(0);
        m_src[j] = m_i;
        v_src[j] = valid_i;
      end else begin
        p_src[j] = p_q[j];
        m_src[j] = m_p_q[j];
        v_src[j] = v_p_q[j];
      end
      // Round half away from zero: negative values take one less.
      rnd_c  = prod_q[j] + HALF - PRW'(prod_q[j][PRW-1]);
      sh_c   = rnd_c >>> FRAC_BITS;
      p_d[j] = sh_c[PW-1:0] + coef_at(j + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NS; j++) begin
      prod_q[j]   <= p_src[j] * $signed({1'b0, m_src[j]});
      p_q[j+1]    <= p_d[j];
      if (j < NS - 1) begin
        m_prod_q[j] <= m_src[j];
        m_p_q[j+1]  <= m_prod_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NS; j++) begin
        v_prod_q[j] <= 1'b0;
        v_p_q[j+1]  <= 1'b0;
      end
    end else begin
      for (int j = 0; j < NS; j++) begin
        v_prod_q[j] <= v_src[j];
        v_p_q[j+1]  <= v_prod_q[j];
      end
    end
  end

  assign valid_o = v_p_q[NS];
  assign p_o     = p_q[NS];

endmodule

>>> rtl/fast_arcsine_top.sv
// Top level of the fixed-point arcsine block: input stage, alignment of the two
// pipelines and the output stages. Depends on fa_pkg, fa_horner and fa_isqrt.
//
// Usage. A beat is offered on value_in_i together with start_i and is taken at
// a rising clock edge where start_i is high and busy_o is low. busy_o is held
// low: the block is a free-running pipeline and takes a new beat in every
// clock cycle, so sustained throughput is one angle per cycle.
// Each result beat appears on angle_out_o for exactly one cycle, marked by
// valid_o, in the order the arguments were taken. The receiver cannot stall
// the block, and nothing inside ever waits, so no beat is lost or repeated.
// The time from the accepting edge to the result is set by the longer of two
// parallel pipelines, the polynomial (seven multiply-add steps of two stages
// each) and the square root (one result bit per stage plus a rounding stage);
// the shorter one is padded. Around them sit one input stage (magnitude and
// 1 - |x| with the clamp) and three output stages (product, rounding, sign
// restore with saturation). Reset clears only the valid bits; payload
// registers keep whatever they hold and no result is strobed until a beat
// taken after reset comes out. The block holds no state between beats, and
// arguments of magnitude one or more give plus or minus pi/2.
module fast_arcsine_top #(
  parameter int unsigned FRAC_BITS = fa_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [fa_pkg::DATA_W-1:0]    value_in_i,
  output logic                                valid_o,
  output logic signed [fa_pkg::DATA_W-1:0]    angle_out_o
);
  import fa_pkg::*;

  localparam int unsigned MW  = (FRAC_BITS < 16) ? FRAC_BITS : 16;
  localparam int unsigned PW  = FRAC_BITS + 3;
  localparam int unsigned OW  = FRAC_BITS + 1;
  localparam int unsigned CW  = (FRAC_BITS + 1 > DATA_W) ? FRAC_BITS + 1 : DATA_W;
  localparam int unsigned FW  = PW + FRAC_BITS + 2;
  localparam int unsigned YW  = PW + 1;
  localparam int unsigned SW  = (YW > DATA_W + 1) ? YW : DATA_W + 1;
  localparam int unsigned HL  = 2 * HORNER_STEPS;
  localparam int unsigned SL  = FRAC_BITS + 2;
  localparam int unsigned ML  = (HL > SL) ? HL : SL;
  localparam int unsigned DP  = ML - HL;
  localparam int unsigned DR  = ML - SL;
  localparam int unsigned NNL = ML + 2;

  localparam logic [CW-1:0]         ONE_C   = CW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0]  HALF_PI = PW'(coef_round(HALF_PI_Q30, FRAC_BITS));
  localparam logic signed [FW-1:0]  HALF_F  = FW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0]  SAT_HI  = SW'(32767);
  localparam logic signed [SW-1:0]  SAT_LO  = SW'(-32768);

  // Input stage: magnitude, clamped 1 - |x| and the polynomial argument.
  logic [DATA_W-1:0] mag_c;
  logic              over_c;
  logic              vld0_q;
  logic              nonneg0_q;
  logic [OW-1:0]     omx_q;
  logic [MW-1:0]     meff_q;

  assign mag_c  = value_in_i[DATA_W-1] ? (~$unsigned(value_in_i) + DATA_W'(1))
                                       : $unsigned(value_in_i);
  assign over_c = CW'(mag_c) >= ONE_C;

  always_ff @(posedge clk_i) begin
    nonneg0_q <= ~value_in_i[DATA_W-1];
    // At or beyond one the root is zero, so the polynomial argument does not
    // matter; zero keeps the polynomial inside its narrow range.
    omx_q     <= over_c ? '0 : OW'(ONE_C - CW'(mag_c));
    meff_q    <= over_c ? '0 : mag_c[MW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start_i & ~busy_o;
    end
  end

  assign busy_o = 1'b0;

  // The two parallel pipelines.
  logic                 p_vld_h;
  logic signed [PW-1:0] p_h;
  logic                 r_vld_h;
  logic [OW-1:0]        root_h;

  fa_horner #(
    .FRAC_BITS(FRAC_BITS)
  ) u_horner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vld0_q),
    .m_i    (meff_q),
    .valid_o(p_vld_h),
    .p_o    (p_h)
  );

  fa_isqrt #(
    .FRAC_BITS(FRAC_BITS)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vld0_q),
    .omx_i  (omx_q),
    .valid_o(r_vld_h),
    .root_o (root_h)
  );

  // Pad the shorter pipeline so polynomial and root meet in the same cycle.
  logic                 p_vld_al;
  logic signed [PW-1:0] p_al;
  logic                 r_vld_al;
  logic [OW-1:0]        root_al;

  if (DP > 0) begin : g_pdly
    logic signed [PW-1:0] pd_q  [DP];
    logic                 pvd_q [DP];
    always_ff @(posedge clk_i) begin
      pd_q[0] <= p_h;
      for (int k = 1; k < DP; k++) begin
        pd_q[k] <= pd_q[k-1];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int k = 0; k < DP; k++) begin
          pvd_q[k] <= 1'b0;
        end
      end else begin
        pvd_q[0] <= p_vld_h;
        for (int k = 1; k < DP; k++) begin
          pvd_q[k] <= pvd_q[k-1];
        end
      end
    end
    assign p_al     = pd_q[DP-1];
    assign p_vld_al = pvd_q[DP-1];
  end else begin : g_pnodly
    assign p_al     = p_h;
    assign p_vld_al = p_vld_h;
  end

  if (DR > 0) begin : g_rdly
    logic [OW-1:0] rd_q  [DR];
    logic          rvd_q [DR];
    always_ff @(posedge clk_i) begin
      rd_q[0] <= root_h;
      for (int k = 1; k < DR; k++) begin
        rd_q[k] <= rd_q[k-1];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int k = 0; k < DR; k++) begin
          rvd_q[k] <= 1'b0;
        end
      end else begin
        rvd_q[0] <= r_vld_h;
        for (int k = 1; k < DR; k++) begin
          rvd_q[k] <= rvd_q[k-1];
        end
      end
    end
    assign root_al  = rd_q[DR-1];
    assign r_vld_al = rvd_q[DR-1];
  end else begin : g_rnodly
    assign root_al  = root_h;
    assign r_vld_al = r_vld_h;
  end

  // The sign travels alongside both pipelines up to the sign-restore stage.
  logic nn_q [NNL];

  always_ff @(posedge clk_i) begin
    nn_q[0] <= nonneg0_q;
    for (int k = 1; k < NNL; k++) begin
      nn_q[k] <= nn_q[k-1];
    end
  end

  // Output stages: product, rounding, sign restore with saturation.
  logic signed [FW-1:0]     fprod_q;
  logic signed [FW-1:0]     frnd_c;
  logic signed [FW-1:0]     fsh_c;
  logic signed [PW-1:0]     r_q;
  logic signed [YW-1:0]     y_c;
  logic signed [SW-1:0]     ys_c;
  logic signed [DATA_W-1:0] angle_d;
  logic signed [DATA_W-1:0] angle_q;
  logic                     vm_q;
  logic                     vr_q;
  logic                     vout_q;

  always_comb begin
    frnd_c = fprod_q + HALF_F - FW'(fprod_q[FW-1]);
    fsh_c  = frnd_c >>> FRAC_BITS;
    if (nn_q[NNL-1]) begin
      y_c = YW'(HALF_PI) - YW'(r_q);
    end else begin
      y_c = YW'(r_q) - YW'(HALF_PI);
    end
    ys_c = SW'(y_c);
    if (ys_c > SAT_HI) begin
      angle_d = SAT_HI[DATA_W-1:0];
    end else if (ys_c < SAT_LO) begin
      angle_d = SAT_LO[DATA_W-1:0];
    end else begin
      angle_d = ys_c[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    fprod_q <= p_al * $signed({1'b0, root_al});
    r_q     <= fsh_c[PW-1:0];
    angle_q <= angle_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q   <= 1'b0;
      vr_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      vm_q   <= p_vld_al;
      vr_q   <= vm_q;
      vout_q <= vr_q;
    end
  end

  assign valid_o     = vout_q;
  assign angle_out_o = angle_q;

  // Polynomial and root must arrive at the product stage together.
  a_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_al == r_vld_al)
    else $error("polynomial and root pipelines out of step");

  // A clamped argument must also zero the polynomial argument.
  a_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld0_q && omx_q == '0) |-> meff_q == '0)
    else $error("clamp applied to the root only");

  a_omx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld0_q |-> CW'(omx_q) <= ONE_C)
    else $error("one minus magnitude above one");

endmodule

>>> sim/fast_arcsine_top_test.sv
// Self-checking testbench for the fixed-point arcsine block fast_arcsine_top.
// It predicts every angle from the argument and compares the results in order.
// Depends on fa_pkg and the RTL of fast_arcsine_top.
`timescale 1ns / 100ps

module fast_arcsine_top_test;

  localparam int unsigned FRAC = fa_pkg::FRAC_BITS_DEF;

  // Run length and pacing.
  localparam int unsigned RANDOM_BEATS = 900;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam time         RUN_LIMIT    = 2ms;

  // Polynomial coefficients in Q30, highest power first, signs included.
  // The last one is pi/2, which is also the offset for the sign restore.
  localparam longint COEF_Q30 [0:7] = '{
    -64'sd1355589, 64'sd7161955, -64'sd18348235, 64'sd33169905,
    -64'sd53874249, 64'sd95540460, -64'sd230423709, 64'sd1686629690
  };

  typedef logic signed [fa_pkg::DATA_W-1:0] fixed_t;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   start_i     = 1'b0;
  fixed_t value_in_i  = '0;
  logic   busy_o;
  logic   valid_o;
  fixed_t angle_out_o;

  fast_arcsine_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .value_in_i (value_in_i),
    .valid_o    (valid_o),
    .angle_out_o(angle_out_o)
  );

  always #2 clk_i = ~clk_i;

  // Arguments still to be sent, and angles still to come back, oldest first.
  fixed_t arg_q[$];
  fixed_t angle_q[$];
  int     err_cnt = 0;

  // Arithmetic shift right by s with ties rounded away from zero.
  function automatic longint shift_round(input longint v, input int s);
    longint mag;
    if (s <= 0) begin
      return v;
    end
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -mag : mag;
  endfunction

  // Integer square root rounded to the nearest integer.
  function automatic longint sqrt_nearest(input longint n);
    longint rem;
    longint res;
    longint bitv;
    rem  = n;
    res  = 0;
    bitv = longint'(1) << 60;
    while (bitv > rem) begin
      bitv = bitv >> 2;
    end
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (rem > res) begin
      res = res + 1;
    end
    return res;
  endfunction

  // Expected angle for one argument: acos(|x|) as root times polynomial,
  // then folded around pi/2 by the sign of the argument.
  function automatic fixed_t arcsine_of(input fixed_t arg);
    longint mag;
    longint one_minus;
    longint root;
    longint poly;
    longint half_pi;
    longint prod;
    longint angle;
    mag       = (arg < 0) ? -longint'(arg) : longint'(arg);
    one_minus = (longint'(1) << FRAC) - mag;
    if (one_minus < 0) begin
      one_minus = 0;
    end
    root    = sqrt_nearest(one_minus << FRAC);
    half_pi = shift_round(COEF_Q30[7], 30 - FRAC);
    poly    = shift_round(COEF_Q30[0], 30 - FRAC);
    for (int k = 1; k <= 7; k++) begin
      poly = shift_round(poly * mag, FRAC) + shift_round(COEF_Q30[k], 30 - FRAC);
    end
    prod  = shift_round(poly * root, FRAC);
    angle = (arg < 0) ? (prod - half_pi) : (half_pi - prod);
    if (angle > 32767) begin
      angle = 32767;
    end
    if (angle < -32768) begin
      angle = -32768;
    end
    return fixed_t'(angle);
  endfunction

  // Driver. The sender works in bursts of random length separated by random
  // gaps; about a third of the gaps last a single cycle, and within a burst
  // the beats follow back to back. The head of arg_q is offered until it is
  // taken, and the monitor pops it at the accepting edge. While idle the
  // argument port carries random noise.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (burst_left > 0 && arg_q.size() > 0) begin
      start_i    <= 1'b1;
      value_in_i <= arg_q[0];
      burst_left <= burst_left - 1;
    end else begin
      start_i    <= 1'b0;
      value_in_i <= fixed_t'($urandom);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else begin
        burst_left <= $urandom_range(1, 48);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // Monitor. Results are checked before the beat taken at the same edge is
  // added, so a stray strobe can never be matched by a fresh expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (angle_q.size() == 0) begin
          $display("%0t: unexpected angle beat, expected none actual %0d",
                   $time, angle_out_o);
          err_cnt++;
        end else begin
          if (angle_out_o !== angle_q[0]) begin
            $display("%0t: angle_out mismatch, expected %0d actual %0d",
                     $time, angle_q[0], angle_out_o);
            err_cnt++;
          end
          void'(angle_q.pop_front());
        end
      end
      if (start_i && !busy_o) begin
        angle_q.push_back(arcsine_of(value_in_i));
        void'(arg_q.pop_front());
      end
    end
  end

  // Random argument: mostly the nominal range, some near plus or minus one
  // where the root is small, and some anywhere in the 16-bit range.
  function automatic fixed_t random_arg();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      return fixed_t'(int'($urandom_range(0, 32768)) - 16384);
    end else if (sel == 8) begin
      return fixed_t'((($urandom_range(0, 1) != 0) ? 16384 : -16384)
                      + int'($urandom_range(0, 128)) - 64);
    end
    return fixed_t'($urandom_range(0, 65535));
  endfunction

  // Stimulus and end of run.
  initial begin
    // Directed beats: zero, the smallest steps, exactly one, just inside and
    // just outside one, the most negative code (magnitude two), the largest
    // positive code, and a few interior points and bit patterns.
    fixed_t directed[$] = '{
      16'sd0, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384, 16'sd16383, -16'sd16383,
      16'sd16385, -16'sd16385, 16'sd32767, -16'sd32768, 16'sd8192, -16'sd8192,
      16'sd4096, -16'sd4096, 16'sd12000, -16'sd12000, 16'sd21845, -16'sd21846,
      16'sd16000, -16'sd16000, 16'sd100
    };
    foreach (directed[k]) begin
      arg_q.push_back(directed[k]);
    end
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      arg_q.push_back(random_arg());
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (arg_q.size() != 0) begin
      @(posedge clk_i);
    end
    while (angle_q.size() != 0) begin
      @(posedge clk_i);
    end
    // The block has no beat that gives no result, so this only catches
    // strobes that come out after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("fast_arcsine_top_test: PASS");
    end else begin
      $display("fast_arcsine_top_test: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake or lost results.
  initial begin
    #(RUN_LIMIT);
    $display("fast_arcsine_top_test: FAIL");
    $finish;
  end

endmodule
